// ----- hw/rtl/sorted_array_priority_queue_top_assert.svh -----
// assertion macros for the sorted array priority queue
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SAPQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sorted array priority queue: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define SAPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sorted array priority queue: next-cycle check failed");

// expression must hold at every clock edge out of reset
`define SAPQ_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("sorted array priority queue: invariant failed");

`endif

// ----- hw/rtl/spapq_pkg.sv -----
// shared types and codes for the sorted array priority queue
package spapq_pkg;

    // request kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_READ,
        ST_INS_STEP,
        ST_REM_READ,
        ST_REM_OUT,
        ST_EMIT
    } state_t;

    // which logical slot the memory read port looks at
    typedef enum logic [1:0] {
        RD_PREV,      // slot j-1
        RD_PREV2,     // slot j-2
        RD_HEAD,      // front slot
        RD_HEAD_NEXT  // slot after the front
    } rd_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic    load;       // latch a new request
        rd_sel_t rd_sel;
        logic    shift;      // move slot j-1 up into slot j
        logic    place;      // write the new key into slot j
        logic    mark_drop;  // insert hit a full store
        logic    pop;        // hand out the front key
        logic    emit;       // hand out a keyless result
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;     // output register can take a result
        logic full;
        logic j_zero;
        logic key_greater;  // key read from slot j-1 is above the new key
        logic n_zero;
        logic n_one;
    } status_t;

endpackage

// ----- hw/rtl/spapq_ctrl.sv -----
// controller state machine for the sorted array priority queue
module spapq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_kind,
    output logic               s_ready,
    output spapq_pkg::cmd_t    cmd,
    input  spapq_pkg::status_t status
);

    spapq_pkg::state_t state_reg;
    spapq_pkg::state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spapq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        cmd.load      = 1'b0;
        cmd.rd_sel    = spapq_pkg::RD_HEAD;
        cmd.shift     = 1'b0;
        cmd.place     = 1'b0;
        cmd.mark_drop = 1'b0;
        cmd.pop       = 1'b0;
        cmd.emit      = 1'b0;
        case (state_reg)
            spapq_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_kind == spapq_pkg::KIND_INSERT) begin
                        state_next = spapq_pkg::ST_INS_READ;
                    end else begin
                        state_next = spapq_pkg::ST_REM_READ;
                    end
                end
            end
            spapq_pkg::ST_INS_READ: begin
                cmd.rd_sel = spapq_pkg::RD_PREV;
                if (status.full) begin
                    cmd.mark_drop = 1'b1;
                    state_next    = spapq_pkg::ST_EMIT;
                end else begin
                    state_next = spapq_pkg::ST_INS_STEP;
                end
            end
            spapq_pkg::ST_INS_STEP: begin
                // shift one larger key per cycle, then drop the new key in
                if (!status.j_zero && status.key_greater) begin
                    cmd.shift  = 1'b1;
                    cmd.rd_sel = spapq_pkg::RD_PREV2;
                end else begin
                    cmd.place  = 1'b1;
                    state_next = spapq_pkg::ST_EMIT;
                end
            end
            spapq_pkg::ST_REM_READ: begin
                cmd.rd_sel = spapq_pkg::RD_HEAD;
                if (status.n_zero) begin
                    state_next = spapq_pkg::ST_EMIT;
                end else begin
                    state_next = spapq_pkg::ST_REM_OUT;
                end
            end
            spapq_pkg::ST_REM_OUT: begin
                // one popped key per cycle while the output drains
                if (status.out_free) begin
                    cmd.pop    = 1'b1;
                    cmd.rd_sel = spapq_pkg::RD_HEAD_NEXT;
                    if (status.n_one) begin
                        state_next = spapq_pkg::ST_IDLE;
                    end
                end else begin
                    cmd.rd_sel = spapq_pkg::RD_HEAD;
                end
            end
            spapq_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = spapq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = spapq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/spapq_dp.sv -----
// datapath for the sorted array priority queue: key ring memory and result register
module spapq_dp #(
    parameter int DEPTH      = 256,
    parameter int MAX_REMOVE = 64,
    parameter int KEY_BITS   = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  spapq_pkg::cmd_t     cmd,
    output spapq_pkg::status_t  status,
    input  logic signed [31:0]  s_key,
    input  logic [6:0]          s_remove_count,
    input  logic                m_ready,
    output logic                m_valid,
    output logic signed [31:0]  m_removed_key,
    output logic                m_has_key,
    output logic                m_last,
    output logic [8:0]          m_entries_left,
    output logic                m_dropped_full
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int NW    = $clog2(MAX_REMOVE + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    // ring of keys, logical slot 0 at head_reg
    logic [KEY_BITS-1:0] store_mem [DEPTH];
    logic [KEY_BITS-1:0] rd_data_reg;

    logic [AW-1:0]       head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    j_reg, j_next;
    logic [NW-1:0]       n_reg, n_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic                drop_reg, drop_next;

    logic                m_valid_reg, m_valid_next;
    logic signed [31:0]  m_key_reg, m_key_next;
    logic                m_has_reg, m_has_next;
    logic                m_last_reg, m_last_next;
    logic [8:0]          m_left_reg, m_left_next;
    logic                m_drop_reg, m_drop_next;

    logic [CNT_W-1:0]    rd_off;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic [6:0]          rc_sat;
    logic [NW-1:0]       n_load;
    logic                out_free;

    // logical slot to memory address, ring wrap by one compare and subtract
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CNT_W-1:0] off);
        logic [AW:0] s;
        s = {1'b0, head} + (AW + 1)'(off);
        if (s >= (AW + 1)'(DEPTH)) begin
            s = s - (AW + 1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // read slot select
    always_comb begin
        case (cmd.rd_sel)
            spapq_pkg::RD_PREV:      rd_off = (j_reg == '0) ? '0 : j_reg - CNT_W'(1);
            spapq_pkg::RD_PREV2:     rd_off = (j_reg < CNT_W'(2)) ? '0 : j_reg - CNT_W'(2);
            spapq_pkg::RD_HEAD_NEXT: rd_off = CNT_W'(1);
            default:                 rd_off = '0;
        endcase
        rd_addr = phys(head_reg, rd_off);
        wr_addr = phys(head_reg, j_reg);
    end

    // key memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.shift || cmd.place) begin
            store_mem[wr_addr] <= cmd.shift ? rd_data_reg : key_reg;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // remove count clamped to the limit and to what is stored
    always_comb begin
        rc_sat = (s_remove_count > 7'(MAX_REMOVE)) ? 7'(MAX_REMOVE) : s_remove_count;
        n_load = (CMP_W'(rc_sat) > CMP_W'(count_reg)) ? NW'(count_reg) : NW'(rc_sat);
    end

    assign out_free = !m_valid_reg || m_ready;

    // queue bookkeeping
    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        key_next   = key_reg;
        drop_next  = drop_reg;
        if (cmd.load) begin
            key_next  = KEY_BITS'($unsigned(s_key));
            j_next    = count_reg;
            n_next    = n_load;
            drop_next = 1'b0;
        end
        if (cmd.mark_drop) begin
            drop_next = 1'b1;
        end
        if (cmd.shift) begin
            j_next = j_reg - CNT_W'(1);
        end
        if (cmd.place) begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.pop) begin
            head_next  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
            count_next = count_reg - CNT_W'(1);
            n_next     = n_reg - NW'(1);
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_key_next   = m_key_reg;
        m_has_next   = m_has_reg;
        m_last_next  = m_last_reg;
        m_left_next  = m_left_reg;
        m_drop_next  = m_drop_reg;
        if (cmd.pop) begin
            m_valid_next = 1'b1;
            m_key_next   = 32'(rd_data_reg);
            m_has_next   = 1'b1;
            m_last_next  = (n_reg == NW'(1));
            m_left_next  = 9'(count_reg - CNT_W'(1));
            m_drop_next  = 1'b0;
        end else if (cmd.emit) begin
            m_valid_next = 1'b1;
            m_key_next   = '0;
            m_has_next   = 1'b0;
            m_last_next  = 1'b1;
            m_left_next  = 9'(count_reg);
            m_drop_next  = drop_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            j_reg       <= '0;
            n_reg       <= '0;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            j_reg       <= j_next;
            n_reg       <= n_next;
            drop_reg    <= drop_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        m_key_reg  <= m_key_next;
        m_has_reg  <= m_has_next;
        m_last_reg <= m_last_next;
        m_left_reg <= m_left_next;
        m_drop_reg <= m_drop_next;
    end

    // status back to the controller
    always_comb begin
        status.out_free    = out_free;
        status.full        = (count_reg == CNT_W'(DEPTH));
        status.j_zero      = (j_reg == '0);
        status.key_greater = ($signed(rd_data_reg) > $signed(key_reg));
        status.n_zero      = (n_reg == '0);
        status.n_one       = (n_reg == NW'(1));
    end

    assign m_valid        = m_valid_reg;
    assign m_removed_key  = m_key_reg;
    assign m_has_key      = m_has_reg;
    assign m_last         = m_last_reg;
    assign m_entries_left = m_left_reg;
    assign m_dropped_full = m_drop_reg;

endmodule

// ----- hw/rtl/sorted_array_priority_queue_top.sv -----
// insert: each stored key larger than the new one is shifted up a slot, then the new key
// is placed and a result is emitted; an insert into a full store is dropped and flagged
// remove of n keys: the front key is read, then one key per cycle is popped while the
// result register is free; a remove of none emits a keyless result; a full result
// register stalls the request until the consumer takes it
// synchronous active-low reset empties the queue at once; key memory is not cleared
`include "sorted_array_priority_queue_top_assert.svh"

module sorted_array_priority_queue_top #(
    parameter int DEPTH      = 256,
    parameter int MAX_REMOVE = 64,
    parameter int KEY_BITS   = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic signed [31:0] s_key,
    input  logic [6:0]         s_remove_count,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_removed_key,
    output logic               m_has_key,
    output logic               m_last,
    output logic [8:0]         m_entries_left,
    output logic               m_dropped_full
);

    spapq_pkg::cmd_t    cmd;
    spapq_pkg::status_t status;

    // controller
    spapq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // datapath
    spapq_dp #(
        .DEPTH      (DEPTH),
        .MAX_REMOVE (MAX_REMOVE),
        .KEY_BITS   (KEY_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_key          (s_key),
        .s_remove_count (s_remove_count),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_removed_key  (m_removed_key),
        .m_has_key      (m_has_key),
        .m_last         (m_last),
        .m_entries_left (m_entries_left),
        .m_dropped_full (m_dropped_full)
    );

    // at most one datapath action per cycle
    `SAPQ_ASSERT_ALWAYS(a_one_action, aclk, aresetn, $onehot0({cmd.shift, cmd.place, cmd.pop, cmd.emit}))
    // a result is never written over one still waiting
    `SAPQ_ASSERT_NOW(a_no_overwrite, aclk, aresetn, cmd.pop || cmd.emit, status.out_free)
    // an accepted request keeps the block busy for at least the next cycle
    `SAPQ_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // the last pop of a remove frees the block for the next request
    `SAPQ_ASSERT_NEXT(a_idle_after_last_pop, aclk, aresetn, cmd.pop && status.n_one, s_ready)

endmodule

// ----- tb/sapq_checker.sv -----
// result checker for the sorted array priority queue: tracks held keys and compares every result
module sapq_checker #(
    parameter int DEPTH      = 256,
    parameter int MAX_REMOVE = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_kind,
    input  logic signed [31:0] s_key,
    input  logic [6:0]         s_remove_count,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_removed_key,
    input  logic               m_has_key,
    input  logic               m_last,
    input  logic [8:0]         m_entries_left,
    input  logic               m_dropped_full,
    output int                 mismatch_count,
    output int                 results_due
);

    // one result beat as the block should present it
    typedef struct packed {
        logic [31:0] removed_key;
        logic        has_key;
        logic        last;
        logic [8:0]  entries_left;
        logic        dropped_full;
    } pq_result_t;

    // keys held by the queue, smallest first
    logic signed [31:0] held_keys[$];
    // results owed by the block, oldest first
    pq_result_t         results_owed[$];
    int                 mismatches = 0;

    // apply one request to the held keys and queue up the results it causes
    task automatic predict_request(input logic kind, input logic signed [31:0] key,
                                   input logic [6:0] count);
        int         pos;
        int         take;
        pq_result_t res;
        res      = '0;
        res.last = 1'b1;
        if (kind == spapq_pkg::KIND_INSERT) begin
            if (held_keys.size() >= DEPTH) begin
                // store full: key is lost, nothing moves
                res.dropped_full = 1'b1;
                res.entries_left = 9'(DEPTH);
            end else begin
                // new key goes after any equal keys
                pos = held_keys.size();
                while (pos > 0 && held_keys[pos-1] > key)
                    pos--;
                held_keys.insert(pos, key);
                res.entries_left = 9'(held_keys.size());
            end
            results_owed.push_back(res);
        end else begin
            // count saturates first, then clamps to what is held
            take = int'(count);
            if (take > MAX_REMOVE)
                take = MAX_REMOVE;
            if (take > held_keys.size())
                take = held_keys.size();
            if (take == 0) begin
                res.entries_left = 9'(held_keys.size());
                results_owed.push_back(res);
            end else begin
                for (int i = 0; i < take; i++) begin
                    res.removed_key  = held_keys.pop_front();
                    res.has_key      = 1'b1;
                    res.last         = (i == take - 1);
                    res.entries_left = 9'(held_keys.size());
                    results_owed.push_back(res);
                end
            end
        end
    endtask

    // watch both channels on every edge
    always @(posedge aclk) begin : watch
        pq_result_t want;
        if (!aresetn) begin
            held_keys.delete();
            results_owed.delete();
        end else begin
            if (s_valid && s_ready)
                predict_request(s_kind, s_key, s_remove_count);
            if (m_valid && m_ready) begin
                if (results_owed.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result at %0t: key %0d has %b last %b left %0d drop %b",
                                 $time, m_removed_key, m_has_key, m_last, m_entries_left,
                                 m_dropped_full);
                end else begin
                    want = results_owed.pop_front();
                    if (m_removed_key !== want.removed_key || m_has_key !== want.has_key ||
                        m_last !== want.last || m_entries_left !== want.entries_left ||
                        m_dropped_full !== want.dropped_full) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result mismatch at %0t", $time);
                            $display("  expected key %0d has %b last %b left %0d drop %b",
                                     $signed(want.removed_key), want.has_key, want.last,
                                     want.entries_left, want.dropped_full);
                            $display("  got      key %0d has %b last %b left %0d drop %b",
                                     m_removed_key, m_has_key, m_last, m_entries_left,
                                     m_dropped_full);
                        end
                    end
                end
            end
        end
        mismatch_count <= mismatches;
        results_due    <= results_owed.size();
    end

endmodule

// ----- tb/tb.sv -----
// testbench top for the sorted array priority queue: request stimulus, stalls and verdict
module tb;

    localparam int DEPTH        = 256;
    localparam int MAX_REMOVE   = 64;
    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 2_000_000;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic               s_kind         = spapq_pkg::KIND_INSERT;
    logic signed [31:0] s_key          = '0;
    logic [6:0]         s_remove_count = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic signed [31:0] m_removed_key;
    logic               m_has_key;
    logic               m_last;
    logic [8:0]         m_entries_left;
    logic               m_dropped_full;

    int mismatch_count;
    int results_due;
    int cycle_count = 0;
    int tx_idle_pct = 13;
    int rx_idle_pct = 86;
    // keys the queue should hold, used only to steer the stimulus
    int fill_level  = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    sorted_array_priority_queue_top #(
        .DEPTH      (DEPTH),
        .MAX_REMOVE (MAX_REMOVE),
        .KEY_BITS   (32)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_key          (s_key),
        .s_remove_count (s_remove_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_removed_key  (m_removed_key),
        .m_has_key      (m_has_key),
        .m_last         (m_last),
        .m_entries_left (m_entries_left),
        .m_dropped_full (m_dropped_full)
    );

    sapq_checker #(
        .DEPTH      (DEPTH),
        .MAX_REMOVE (MAX_REMOVE)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_key          (s_key),
        .s_remove_count (s_remove_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_removed_key  (m_removed_key),
        .m_has_key      (m_has_key),
        .m_last         (m_last),
        .m_entries_left (m_entries_left),
        .m_dropped_full (m_dropped_full),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // present one request, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_request(input logic kind, input logic signed [31:0] key,
                                input logic [6:0] count);
        int take;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_key          <= key;
        s_remove_count <= count;
        do @(posedge aclk); while (!s_ready);
        if (kind == spapq_pkg::KIND_INSERT) begin
            if (fill_level < DEPTH)
                fill_level++;
        end else begin
            take = int'(count);
            if (take > MAX_REMOVE)
                take = MAX_REMOVE;
            if (take > fill_level)
                take = fill_level;
            fill_level -= take;
        end
    endtask

    // hold off new requests until every owed result is out
    task automatic pause_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_due != 0);
    endtask

    initial begin
        logic               kind;
        logic signed [31:0] key;
        logic [6:0]         count;
        bit                 climbing;
        int                 overflow_tries;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty removes, key extremes, equal keys, saturated and clamped counts
        send_request(spapq_pkg::KIND_REMOVE, '0, 7'd0);
        send_request(spapq_pkg::KIND_REMOVE, '0, 7'd5);
        send_request(spapq_pkg::KIND_INSERT, 32'sd0, 7'd0);
        send_request(spapq_pkg::KIND_INSERT, 32'h7FFFFFFF, 7'd0);
        send_request(spapq_pkg::KIND_INSERT, 32'h80000000, 7'd0);
        send_request(spapq_pkg::KIND_INSERT, -32'sd1, 7'd0);
        send_request(spapq_pkg::KIND_INSERT, 32'sd1, 7'd0);
        send_request(spapq_pkg::KIND_INSERT, 32'sd0, 7'd0);
        send_request(spapq_pkg::KIND_INSERT, -32'sd1, 7'd0);
        send_request(spapq_pkg::KIND_REMOVE, '0, 7'd0);
        send_request(spapq_pkg::KIND_REMOVE, '0, 7'd2);
        send_request(spapq_pkg::KIND_REMOVE, '1, 7'd127);
        send_request(spapq_pkg::KIND_INSERT, 32'sd3, 7'd127);
        send_request(spapq_pkg::KIND_INSERT, -32'sd7, 7'd0);
        send_request(spapq_pkg::KIND_INSERT, 32'sd3, 7'd0);
        send_request(spapq_pkg::KIND_INSERT, 32'sd100, 7'd0);
        send_request(spapq_pkg::KIND_INSERT, -32'sd100, 7'd0);
        send_request(spapq_pkg::KIND_INSERT, 32'h55555555, 7'd0);
        send_request(spapq_pkg::KIND_INSERT, 32'hAAAAAAAA, 7'd0);
        send_request(spapq_pkg::KIND_REMOVE, '0, 7'd3);
        send_request(spapq_pkg::KIND_REMOVE, '0, 7'd64);

        // random: climb to a full store, push a few inserts past it, then drain
        climbing       = 1'b1;
        overflow_tries = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                pause_until_drained();
                tx_idle_pct = 86;
                rx_idle_pct = 13;
            end else if (i == 2 * RANDOM_ITEMS / 3) begin
                pause_until_drained();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            if (climbing)
                kind = ($urandom_range(0, 99) < 96) ? spapq_pkg::KIND_INSERT
                                                    : spapq_pkg::KIND_REMOVE;
            else
                kind = ($urandom_range(0, 99) < 70) ? spapq_pkg::KIND_REMOVE
                                                    : spapq_pkg::KIND_INSERT;

            // mix full-range keys with a narrow band that gives many equal keys
            if ($urandom_range(0, 9) < 6)
                key = $urandom;
            else
                key = $signed($urandom_range(0, 31)) - 16;

            if (climbing) begin
                count = 7'($urandom_range(0, 3));
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        count = 7'($urandom_range(0, 3));
                    end
                    1: begin
                        count = 7'($urandom_range(0, 16));
                    end
                    2: begin
                        count = 7'($urandom_range(0, 127));
                    end
                    default: begin
                        count = 7'($urandom_range(60, 68));
                    end
                endcase
            end

            // a few inserts into the full store before turning to drain
            if (climbing && kind == spapq_pkg::KIND_INSERT && fill_level >= DEPTH) begin
                overflow_tries++;
                if (overflow_tries >= 4)
                    climbing = 1'b0;
            end

            send_request(kind, key, count);

            if (!climbing && fill_level < 8) begin
                climbing       = 1'b1;
                overflow_tries = 0;
            end
        end

        // let every owed result come out, then a short quiet stretch
        pause_until_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/spapq_pkg.sv
hw/rtl/spapq_ctrl.sv
hw/rtl/spapq_dp.sv
hw/rtl/sorted_array_priority_queue_top.sv
tb/sapq_checker.sv
tb/tb.sv
